// File: sv/timseq_pkg.sv
// shared widths, codes, register map and the microcode store of the macro sequencer
`default_nettype none

package timseq_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned DUR_W   = 16;
   localparam int unsigned SPD_W   = 10;
   localparam int unsigned SOUT_W  = 11;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned PROD_W  = SPD_W + DUR_W;
   localparam int unsigned CNT_W   = 5;
   localparam int unsigned PC_W    = 4;
   localparam int unsigned OP_W    = 4;
   localparam int unsigned COND_W  = 4;

   // phase codes
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_OUTTAKE = 2'd1;
   localparam logic [1:0] PH_SCORE   = 2'd2;

   // motor and load commands
   localparam logic [1:0] ACT_NONE     = 2'd0;
   localparam logic [1:0] ACT_DRIVE    = 2'd1;
   localparam logic [1:0] ACT_STOP     = 2'd2;
   localparam logic [1:0] LOAD_NONE    = 2'd0;
   localparam logic [1:0] LOAD_EXTEND  = 2'd1;
   localparam logic [1:0] LOAD_RETRACT = 2'd2;

   // register map
   localparam logic [IDX_W-1:0] REG_OUTTAKE_TIME  = 3'd0;
   localparam logic [IDX_W-1:0] REG_SCORE_TIME    = 3'd1;
   localparam logic [IDX_W-1:0] REG_BOOST_TIME    = 3'd2;
   localparam logic [IDX_W-1:0] REG_RAMP_END      = 3'd3;
   localparam logic [IDX_W-1:0] REG_START_SPEED   = 3'd4;
   localparam logic [IDX_W-1:0] REG_END_SPEED     = 3'd5;
   localparam logic [IDX_W-1:0] REG_OUTTAKE_SPEED = 3'd6;

   localparam logic [DUR_W-1:0] RST_OUTTAKE_TIME  = 16'd200;
   localparam logic [DUR_W-1:0] RST_SCORE_TIME    = 16'd2500;
   localparam logic [DUR_W-1:0] RST_BOOST_TIME    = 16'd500;
   localparam logic [DUR_W-1:0] RST_RAMP_END      = 16'd1500;
   localparam logic [SPD_W-1:0] RST_START_SPEED   = 10'd500;
   localparam logic [SPD_W-1:0] RST_END_SPEED     = 10'd200;
   localparam logic [SPD_W-1:0] RST_OUTTAKE_SPEED = 10'd600;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
   localparam logic [OP_W-1:0] OP_TAKE      = 4'd1;
   localparam logic [OP_W-1:0] OP_MAG_START = 4'd2;
   localparam logic [OP_W-1:0] OP_MAG_TAIL  = 4'd3;
   localparam logic [OP_W-1:0] OP_RAMP_D    = 4'd4;
   localparam logic [OP_W-1:0] OP_MUL       = 4'd5;
   localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd6;
   localparam logic [OP_W-1:0] OP_MAG_RAMP  = 4'd7;
   localparam logic [OP_W-1:0] OP_SCORE_DRV = 4'd8;
   localparam logic [OP_W-1:0] OP_OUT_DRV   = 4'd9;
   localparam logic [OP_W-1:0] OP_TO_SCORE  = 4'd10;
   localparam logic [OP_W-1:0] OP_FINISH    = 4'd11;
   localparam logic [OP_W-1:0] OP_EMIT      = 4'd12;

   // jump conditions
   localparam logic [COND_W-1:0] C_ALWAYS   = 4'd0;
   localparam logic [COND_W-1:0] C_IN_VALID = 4'd1;
   localparam logic [COND_W-1:0] C_OUT_FREE = 4'd2;
   localparam logic [COND_W-1:0] C_PH_OUT   = 4'd3;
   localparam logic [COND_W-1:0] C_PH_SCORE = 4'd4;
   localparam logic [COND_W-1:0] C_LT_OUT   = 4'd5;
   localparam logic [COND_W-1:0] C_LT_SCORE = 4'd6;
   localparam logic [COND_W-1:0] C_LT_BOOST = 4'd7;
   localparam logic [COND_W-1:0] C_LT_RAMP  = 4'd8;
   localparam logic [COND_W-1:0] C_DIV_LAST = 4'd9;

   // program addresses
   localparam logic [PC_W-1:0] S_TAKE      = 4'd0;
   localparam logic [PC_W-1:0] S_PHASE     = 4'd1;
   localparam logic [PC_W-1:0] S_SCORE_CHK = 4'd2;
   localparam logic [PC_W-1:0] S_SCORE_END = 4'd3;
   localparam logic [PC_W-1:0] S_BOOST     = 4'd4;
   localparam logic [PC_W-1:0] S_TAIL      = 4'd5;
   localparam logic [PC_W-1:0] S_RAMP_D    = 4'd6;
   localparam logic [PC_W-1:0] S_MUL       = 4'd7;
   localparam logic [PC_W-1:0] S_DIV       = 4'd8;
   localparam logic [PC_W-1:0] S_RAMP      = 4'd9;
   localparam logic [PC_W-1:0] S_SCORE_DRV = 4'd10;
   localparam logic [PC_W-1:0] S_OUT_CHK   = 4'd11;
   localparam logic [PC_W-1:0] S_OUT_DRV   = 4'd12;
   localparam logic [PC_W-1:0] S_TO_SCORE  = 4'd13;
   localparam logic [PC_W-1:0] S_FINISH    = 4'd14;
   localparam logic [PC_W-1:0] S_EMIT      = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic              neg;
      logic [PC_W-1:0]   target;
   } uword_type;

   typedef struct packed {
      logic in_valid;
      logic out_free;
      logic ph_out;
      logic ph_score;
      logic lt_out;
      logic lt_score;
      logic lt_boost;
      logic lt_ramp;
      logic div_last;
   } flags_type;

   typedef struct packed {
      logic [DUR_W-1:0] outtake_time;
      logic [DUR_W-1:0] score_time;
      logic [DUR_W-1:0] boost_time;
      logic [DUR_W-1:0] ramp_end;
      logic [SPD_W-1:0] start_speed;
      logic [SPD_W-1:0] end_speed;
      logic [SPD_W-1:0] outtake_speed;
   } cfg_type;

   function automatic uword_type uw(input logic [OP_W-1:0] op, input logic [COND_W-1:0] cond,
                                    input logic neg, input logic [PC_W-1:0] target);
      uword_type w;
      w.op     = op;
      w.cond   = cond;
      w.neg    = neg;
      w.target = target;
      return w;
   endfunction

   // jump to target when (condition xor neg), else fall through; emit wraps to take
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] addr);
      uword_type w;
      unique case (addr)
         S_TAKE:      w = uw(OP_TAKE,      C_IN_VALID, 1'b1, S_TAKE);
         S_PHASE:     w = uw(OP_NOP,       C_PH_OUT,   1'b0, S_OUT_CHK);
         S_SCORE_CHK: w = uw(OP_NOP,       C_PH_SCORE, 1'b1, S_EMIT);
         S_SCORE_END: w = uw(OP_NOP,       C_LT_SCORE, 1'b1, S_FINISH);
         S_BOOST:     w = uw(OP_MAG_START, C_LT_BOOST, 1'b0, S_SCORE_DRV);
         S_TAIL:      w = uw(OP_MAG_TAIL,  C_LT_RAMP,  1'b1, S_SCORE_DRV);
         S_RAMP_D:    w = uw(OP_RAMP_D,    C_ALWAYS,   1'b1, S_TAKE);
         S_MUL:       w = uw(OP_MUL,       C_ALWAYS,   1'b1, S_TAKE);
         S_DIV:       w = uw(OP_DIV_STEP,  C_DIV_LAST, 1'b1, S_DIV);
         S_RAMP:      w = uw(OP_MAG_RAMP,  C_ALWAYS,   1'b1, S_TAKE);
         S_SCORE_DRV: w = uw(OP_SCORE_DRV, C_ALWAYS,   1'b0, S_EMIT);
         S_OUT_CHK:   w = uw(OP_NOP,       C_LT_OUT,   1'b1, S_TO_SCORE);
         S_OUT_DRV:   w = uw(OP_OUT_DRV,   C_ALWAYS,   1'b0, S_EMIT);
         S_TO_SCORE:  w = uw(OP_TO_SCORE,  C_ALWAYS,   1'b0, S_EMIT);
         S_FINISH:    w = uw(OP_FINISH,    C_ALWAYS,   1'b1, S_TAKE);
         S_EMIT:      w = uw(OP_EMIT,      C_OUT_FREE, 1'b1, S_EMIT);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: sv/timseq_req_if.sv
// poll word channel: button level and timestamp
`default_nettype none

interface timseq_req_if import timseq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              button_level;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output button_level, output now_ms, input ready);
   modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

`default_nettype wire

// File: sv/timseq_rsp_if.sv
// command word channel: motor speeds, load command and busy flag
`default_nettype none

interface timseq_rsp_if import timseq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               motor_action;
   logic signed [SOUT_W-1:0] main_speed;
   logic signed [SOUT_W-1:0] score_speed;
   logic signed [SOUT_W-1:0] mid_speed;
   logic [1:0]               load_action;
   logic                     busy_res;

   modport source (output valid, output motor_action, output main_speed, output score_speed,
                   output mid_speed, output load_action, output busy_res, input ready);
   modport sink   (input valid, input motor_action, input main_speed, input score_speed,
                   input mid_speed, input load_action, input busy_res, output ready);
endinterface

`default_nettype wire

// File: sv/timseq_csr_if.sv
// register write channel
`default_nettype none

interface timseq_csr_if import timseq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] addr;
   logic [DUR_W-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// File: sv/timseq_csr.sv
// configuration register file of the macro sequencer
`default_nettype none

module timseq_csr import timseq_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   timseq_csr_if.sink  csr_bus,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_bus.addr)
            REG_OUTTAKE_TIME:  cfg_in.outtake_time  = csr_bus.wdata;
            REG_SCORE_TIME:    cfg_in.score_time    = csr_bus.wdata;
            REG_BOOST_TIME:    cfg_in.boost_time    = csr_bus.wdata;
            REG_RAMP_END:      cfg_in.ramp_end      = csr_bus.wdata;
            REG_START_SPEED:   cfg_in.start_speed   = csr_bus.wdata[SPD_W-1:0];
            REG_END_SPEED:     cfg_in.end_speed     = csr_bus.wdata[SPD_W-1:0];
            REG_OUTTAKE_SPEED: cfg_in.outtake_speed = csr_bus.wdata[SPD_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.outtake_time  <= RST_OUTTAKE_TIME;
         cfg_ff.score_time    <= RST_SCORE_TIME;
         cfg_ff.boost_time    <= RST_BOOST_TIME;
         cfg_ff.ramp_end      <= RST_RAMP_END;
         cfg_ff.start_speed   <= RST_START_SPEED;
         cfg_ff.end_speed     <= RST_END_SPEED;
         cfg_ff.outtake_speed <= RST_OUTTAKE_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/timseq_useq.sv
// microcode sequencer: step counter, control store and conditional jumps
`default_nettype none

module timseq_useq import timseq_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire flags_type       flags,
   output logic [OP_W-1:0]      op
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   uword_type       uword;
   logic            cond_ok;

   assign uword = ucode_rom(pc_ff);
   assign op    = uword.op;

   always_comb begin
      unique case (uword.cond)
         C_ALWAYS:   cond_ok = 1'b1;
         C_IN_VALID: cond_ok = flags.in_valid;
         C_OUT_FREE: cond_ok = flags.out_free;
         C_PH_OUT:   cond_ok = flags.ph_out;
         C_PH_SCORE: cond_ok = flags.ph_score;
         C_LT_OUT:   cond_ok = flags.lt_out;
         C_LT_SCORE: cond_ok = flags.lt_score;
         C_LT_BOOST: cond_ok = flags.lt_boost;
         C_LT_RAMP:  cond_ok = flags.lt_ramp;
         C_DIV_LAST: cond_ok = flags.div_last;
         default:    cond_ok = 1'b0;
      endcase
   end

   // fall-through from the last step wraps back to the take step
   assign pc_in = (cond_ok ^ uword.neg) ? uword.target : pc_ff + PC_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_TAKE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/timseq_div.sv
// restoring serial divider, one quotient bit per step
`default_nettype none

module timseq_div import timseq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic              step,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [DUR_W-1:0]  divisor,
   output logic [PROD_W-1:0]      quot,
   output logic                   rem_nz,
   output logic                   last
);

   logic [PROD_W-1:0] quo_ff;
   logic [PROD_W-1:0] quo_in;
   logic [DUR_W-1:0]  rem_ff;
   logic [DUR_W-1:0]  rem_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [DUR_W:0]    shifted;
   logic [DUR_W+1:0]  diff;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor};
   assign ge      = ~diff[DUR_W+1];

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (load) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(PROD_W);
      end else if (step) begin
         quo_in = {quo_ff[PROD_W-2:0], ge};
         rem_in = ge ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quot   = quo_ff;
   assign rem_nz = (rem_ff != '0);
   assign last   = (cnt_ff == CNT_W'(1));

endmodule

`default_nettype wire

// File: sv/timseq_dpath.sv
// datapath: phase state, elapsed time, speed profile and the command word register
`default_nettype none

module timseq_dpath import timseq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [OP_W-1:0] op,
   input  wire cfg_type     cfg,
   timseq_req_if.sink       req_bus,
   timseq_rsp_if.source     rsp_bus,
   output flags_type        flags
);

   // loop state
   logic                     prev_button_ff, prev_button_in;
   logic [1:0]               phase_ff, phase_in;
   logic [TIME_W-1:0]        phase_start_ff, phase_start_in;

   // per-poll working registers
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [TIME_W-1:0]        elapsed_ff, elapsed_in;
   logic [1:0]               action_ff, action_in;
   logic [1:0]               load_ff, load_in;
   logic signed [SOUT_W-1:0] main_ff, main_in;
   logic signed [SOUT_W-1:0] score_ff, score_in;
   logic signed [SOUT_W-1:0] mid_ff, mid_in;
   logic [SPD_W-1:0]         mag_ff, mag_in;
   logic [DUR_W-1:0]         d_ff, d_in;
   logic [DUR_W-1:0]         w_ff, w_in;
   logic [SPD_W-1:0]         dmag_ff, dmag_in;
   logic                     dneg_ff, dneg_in;

   // result word register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_action_ff;
   logic signed [SOUT_W-1:0] rsp_main_ff;
   logic signed [SOUT_W-1:0] rsp_score_ff;
   logic signed [SOUT_W-1:0] rsp_mid_ff;
   logic [1:0]               rsp_load_ff;
   logic                     rsp_busy_ff;

   logic                     take;
   logic                     emit;
   logic                     out_free;
   logic                     start;
   logic [PROD_W-1:0]        prod;
   logic [PROD_W-1:0]        quot;
   logic                     rem_nz;
   logic                     div_last;
   logic [SOUT_W-1:0]        q_adj;
   logic [SOUT_W-1:0]        ramp_sum;
   logic signed [SOUT_W-1:0] mag_s;

   assign req_bus.ready = (op == OP_TAKE);
   assign take          = req_bus.valid && (op == OP_TAKE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign emit          = out_free && (op == OP_EMIT);
   assign start         = req_bus.button_level && !prev_button_ff && (phase_ff == PH_IDLE);

   assign prod  = PROD_W'(dmag_ff) * PROD_W'(d_ff);
   assign mag_s = $signed({1'b0, mag_ff});

   // floor for a negative slope: one more step down when the division is inexact
   assign q_adj    = quot[SOUT_W-1:0] + {{(SOUT_W-1){1'b0}}, dneg_ff & rem_nz};
   assign ramp_sum = dneg_ff ? {1'b0, cfg.start_speed} - q_adj
                             : {1'b0, cfg.start_speed} + q_adj;

   timseq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (op == OP_MUL),
      .step     (op == OP_DIV_STEP),
      .dividend (prod),
      .divisor  (w_ff),
      .quot     (quot),
      .rem_nz   (rem_nz),
      .last     (div_last)
   );

   always_comb begin
      prev_button_in = prev_button_ff;
      phase_in       = phase_ff;
      phase_start_in = phase_start_ff;
      now_in         = now_ff;
      elapsed_in     = elapsed_ff;
      action_in      = action_ff;
      load_in        = load_ff;
      main_in        = main_ff;
      score_in       = score_ff;
      mid_in         = mid_ff;
      mag_in         = mag_ff;
      d_in           = d_ff;
      w_in           = w_ff;
      dmag_in        = dmag_ff;
      dneg_in        = dneg_ff;
      unique case (op)
         OP_NOP, OP_MUL, OP_DIV_STEP, OP_EMIT: begin
         end
         OP_TAKE: begin
            if (take) begin
               prev_button_in = req_bus.button_level;
               now_in         = req_bus.now_ms;
               action_in      = ACT_NONE;
               main_in        = '0;
               score_in       = '0;
               mid_in         = '0;
               if (start) begin
                  phase_in       = PH_OUTTAKE;
                  phase_start_in = req_bus.now_ms;
                  elapsed_in     = '0;
                  load_in        = LOAD_EXTEND;
               end else begin
                  elapsed_in = req_bus.now_ms - phase_start_ff;
                  load_in    = LOAD_NONE;
               end
            end
         end
         OP_MAG_START: mag_in = cfg.start_speed;
         OP_MAG_TAIL:  mag_in = {1'b0, cfg.end_speed[SPD_W-1:1]};
         OP_RAMP_D: begin
            d_in    = elapsed_ff[DUR_W-1:0] - cfg.boost_time;
            w_in    = cfg.ramp_end - cfg.boost_time;
            dneg_in = cfg.end_speed < cfg.start_speed;
            dmag_in = (cfg.end_speed < cfg.start_speed) ? cfg.start_speed - cfg.end_speed
                                                        : cfg.end_speed - cfg.start_speed;
         end
         OP_MAG_RAMP:  mag_in = ramp_sum[SPD_W-1:0];
         OP_SCORE_DRV: begin
            action_in = ACT_DRIVE;
            main_in   = -mag_s;
            score_in  = mag_s;
            mid_in    = -mag_s;
         end
         OP_OUT_DRV: begin
            action_in = ACT_DRIVE;
            main_in   = $signed({1'b0, cfg.outtake_speed});
            score_in  = $signed({1'b0, cfg.outtake_speed});
            mid_in    = $signed({1'b0, cfg.outtake_speed});
         end
         OP_TO_SCORE: begin
            phase_in       = PH_SCORE;
            phase_start_in = now_ff;
         end
         OP_FINISH: begin
            action_in = ACT_STOP;
            load_in   = LOAD_RETRACT;
            phase_in  = PH_IDLE;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_button_ff <= 1'b0;
         phase_ff       <= PH_IDLE;
         phase_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prev_button_ff <= prev_button_in;
         phase_ff       <= phase_in;
         phase_start_ff <= phase_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      elapsed_ff <= elapsed_in;
      action_ff  <= action_in;
      load_ff    <= load_in;
      main_ff    <= main_in;
      score_ff   <= score_in;
      mid_ff     <= mid_in;
      mag_ff     <= mag_in;
      d_ff       <= d_in;
      w_ff       <= w_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      if (emit) begin
         rsp_action_ff <= action_ff;
         rsp_main_ff   <= main_ff;
         rsp_score_ff  <= score_ff;
         rsp_mid_ff    <= mid_ff;
         rsp_load_ff   <= load_ff;
         rsp_busy_ff   <= (phase_ff != PH_IDLE);
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.motor_action = rsp_action_ff;
   assign rsp_bus.main_speed   = rsp_main_ff;
   assign rsp_bus.score_speed  = rsp_score_ff;
   assign rsp_bus.mid_speed    = rsp_mid_ff;
   assign rsp_bus.load_action  = rsp_load_ff;
   assign rsp_bus.busy_res     = rsp_busy_ff;

   assign flags.in_valid = req_bus.valid;
   assign flags.out_free = out_free;
   assign flags.ph_out   = (phase_ff == PH_OUTTAKE);
   assign flags.ph_score = (phase_ff == PH_SCORE);
   assign flags.lt_out   = elapsed_ff < {{(TIME_W-DUR_W){1'b0}}, cfg.outtake_time};
   assign flags.lt_score = elapsed_ff < {{(TIME_W-DUR_W){1'b0}}, cfg.score_time};
   assign flags.lt_boost = elapsed_ff < {{(TIME_W-DUR_W){1'b0}}, cfg.boost_time};
   assign flags.lt_ramp  = elapsed_ff < {{(TIME_W-DUR_W){1'b0}}, cfg.ramp_end};
   assign flags.div_last = div_last;

`ifndef NO_ASSERTIONS
   a_speeds_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_action_ff != ACT_DRIVE) |->
      (rsp_main_ff == '0 && rsp_score_ff == '0 && rsp_mid_ff == '0))
      else $error("speeds not zero on a word without drive");

   a_retract_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_load_ff == LOAD_RETRACT) |->
      (rsp_action_ff == ACT_STOP && !rsp_busy_ff))
      else $error("retract without stop and idle");

   a_ramp_quot: assert property (@(posedge clock) disable iff (reset)
      (op == OP_MAG_RAMP) |-> (quot[PROD_W-1:SPD_W] == '0))
      else $error("ramp quotient out of speed range");

   a_busy_phase: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_busy_ff == (phase_ff != PH_IDLE)))
      else $error("busy flag disagrees with phase");
`endif

endmodule

`default_nettype wire

// File: sv/timed_intake_macro_sequencer.sv
// Timed intake macro sequencer: one command word for each control-loop poll.
// req_bus carries a poll word (button level, millisecond timestamp); rsp_bus
// returns exactly one command word per poll, in order: motor action, the
// three signed motor speeds, the match-load command and the busy flag.
// csr_bus writes the seven timing and speed registers and is always ready;
// the user must see that it is written only while no poll is in flight,
// as the block does not enforce this. A poll runs as a short microprogram
// from accept until its command word is registered: an idle poll, an
// outtake poll, the end of scoring, boost and tail each take their own
// path, and a poll on the scoring ramp also runs a 26-step serial divider.
// One poll is in flight at a time; the next is accepted once the previous
// word sits in the output register, even if it has not yet been taken.
// While rsp_bus is stalled the word is held and the sequencer waits before
// writing the next one, so nothing is lost or repeated.
// Synchronous reset returns the sequencer to idle, clears the button
// history and loads the registers with their default timings and speeds.
`default_nettype none

module timed_intake_macro_sequencer import timseq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   timseq_req_if.sink   req_bus,
   timseq_rsp_if.source rsp_bus,
   timseq_csr_if.sink   csr_bus
);

   cfg_type         cfg;
   flags_type       flags;
   logic [OP_W-1:0] op;

   timseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   timseq_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   timseq_dpath u_dpath (
      .clock   (clock),
      .reset   (reset),
      .op      (op),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .flags   (flags)
   );

endmodule

`default_nettype wire

// File: tb/sv/timed_intake_macro_sequencer_chk.sv
// checker for the macro sequencer: tracks register writes, predicts every command word, compares
module timed_intake_macro_sequencer_chk import timseq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   timseq_req_if       req_bus,
   timseq_rsp_if       rsp_bus,
   timseq_csr_if       csr_bus,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]               motor_action;
      logic signed [SOUT_W-1:0] main_speed;
      logic signed [SOUT_W-1:0] score_speed;
      logic signed [SOUT_W-1:0] mid_speed;
      logic [1:0]               load_action;
      logic                     busy;
   } cmd_word_type;

   cfg_type           regs;
   logic              prev_button_q;
   logic [1:0]        phase_q;
   logic [TIME_W-1:0] phase_t0;
   cmd_word_type      commands_due[$];
   int unsigned       err_total = 0;

   function automatic logic [SPD_W-1:0] scoring_level(input logic [TIME_W-1:0] e);
      longint lo, hi, span, d, num, q, lvl;
      lo = longint'(regs.start_speed);
      hi = longint'(regs.end_speed);
      if (e < regs.boost_time) return regs.start_speed;
      if (e < regs.ramp_end) begin
         span = longint'(regs.ramp_end) - longint'(regs.boost_time);
         d    = longint'(e) - longint'(regs.boost_time);
         num  = (hi - lo) * d;
         q    = num / span;
         // round towards minus infinity on a falling ramp
         if (num % span != 0 && num < 0) q = q - 1;
         lvl = lo + q;
         return lvl[SPD_W-1:0];
      end
      return regs.end_speed >> 1;
   endfunction

   function automatic cmd_word_type next_command(input logic btn, input logic [TIME_W-1:0] now);
      cmd_word_type      c;
      logic [TIME_W-1:0] el;
      logic [SPD_W-1:0]  lvl;
      c = '0;
      if (btn && !prev_button_q && phase_q == PH_IDLE) begin
         phase_q       = PH_OUTTAKE;
         phase_t0      = now;
         c.load_action = LOAD_EXTEND;
      end
      el = now - phase_t0;
      if (phase_q == PH_OUTTAKE) begin
         if (el < regs.outtake_time) begin
            c.motor_action = ACT_DRIVE;
            c.main_speed   = $signed({1'b0, regs.outtake_speed});
            c.score_speed  = $signed({1'b0, regs.outtake_speed});
            c.mid_speed    = $signed({1'b0, regs.outtake_speed});
         end else begin
            phase_q  = PH_SCORE;
            phase_t0 = now;
         end
      end else if (phase_q == PH_SCORE) begin
         if (el < regs.score_time) begin
            lvl            = scoring_level(el);
            c.motor_action = ACT_DRIVE;
            c.main_speed   = -$signed({1'b0, lvl});
            c.score_speed  = $signed({1'b0, lvl});
            c.mid_speed    = -$signed({1'b0, lvl});
         end else begin
            c.motor_action = ACT_STOP;
            c.load_action  = LOAD_RETRACT;
            phase_q        = PH_IDLE;
         end
      end
      prev_button_q = btn;
      c.busy        = (phase_q != PH_IDLE);
      return c;
   endfunction

   function automatic void check_field(input string name, input logic signed [SOUT_W:0] want,
                                       input logic signed [SOUT_W:0] got);
      if (got !== want) begin
         $display("%t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         err_total++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      cmd_word_type want;
      if (reset) begin
         regs          = '{RST_OUTTAKE_TIME, RST_SCORE_TIME, RST_BOOST_TIME, RST_RAMP_END,
                           RST_START_SPEED, RST_END_SPEED, RST_OUTTAKE_SPEED};
         prev_button_q = 1'b0;
         phase_q       = PH_IDLE;
         phase_t0      = '0;
         commands_due.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.addr)
               REG_OUTTAKE_TIME:  regs.outtake_time  = csr_bus.wdata;
               REG_SCORE_TIME:    regs.score_time    = csr_bus.wdata;
               REG_BOOST_TIME:    regs.boost_time    = csr_bus.wdata;
               REG_RAMP_END:      regs.ramp_end      = csr_bus.wdata;
               REG_START_SPEED:   regs.start_speed   = csr_bus.wdata[SPD_W-1:0];
               REG_END_SPEED:     regs.end_speed     = csr_bus.wdata[SPD_W-1:0];
               REG_OUTTAKE_SPEED: regs.outtake_speed = csr_bus.wdata[SPD_W-1:0];
               default: ;
            endcase
         end
         // a word may still be waiting when its poll's successor is predicted; pop first anyway
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (commands_due.size() == 0) begin
               $display("%t: unexpected command word: action %0d main %0d score %0d mid %0d",
                        $time, rsp_bus.motor_action, rsp_bus.main_speed, rsp_bus.score_speed,
                        rsp_bus.mid_speed);
               err_total++;
            end else begin
               want = commands_due.pop_front();
               check_field("motor_action", want.motor_action, rsp_bus.motor_action);
               check_field("main_speed", want.main_speed, rsp_bus.main_speed);
               check_field("score_speed", want.score_speed, rsp_bus.score_speed);
               check_field("mid_speed", want.mid_speed, rsp_bus.mid_speed);
               check_field("load_action", want.load_action, rsp_bus.load_action);
               check_field("busy_res", want.busy, rsp_bus.busy_res);
            end
         end
         if (req_bus.valid && req_bus.ready)
            commands_due.push_back(next_command(req_bus.button_level, req_bus.now_ms));
      end
      mismatches  <= err_total;
      outstanding <= commands_due.size();
   end

endmodule

// File: tb/sv/timed_intake_macro_sequencer_tb.sv
// testbench top for the macro sequencer: clock, reset, poll stimulus, register settings, verdict
module timed_intake_macro_sequencer_tb import timseq_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT       = 1_000_000;
   localparam int          SETTLE_CYCLES     = 64;
   localparam int          N_SETTINGS        = 8;
   localparam int          POLLS_PER_SETTING = 250;
   localparam int          STEADY_SETTING    = 4;
   localparam int          IDLE_PCT          = 28;
   // no register lives at this index
   localparam logic [IDX_W-1:0] REG_SPARE    = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        steady = 1'b0;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;

   timseq_req_if req_bus ();
   timseq_rsp_if rsp_bus ();
   timseq_csr_if csr_bus ();

   timed_intake_macro_sequencer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   timed_intake_macro_sequencer_chk u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .mismatches  (mismatch_count),
      .outstanding (pending_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%t: timeout after %0d cycles", $time, cycle_count);
         $display("timed_intake_macro_sequencer_tb: FAIL");
         $finish;
      end
   end

   task automatic send_poll(input logic btn, input logic [TIME_W-1:0] stamp);
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.button_level <= btn;
      req_bus.now_ms       <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.wdata <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic drain_commands();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input cfg_type s);
      logic [DUR_W-1:0] junk;
      junk = DUR_W'($urandom);
      drain_commands();
      csr_write(REG_OUTTAKE_TIME, s.outtake_time);
      csr_write(REG_SCORE_TIME, s.score_time);
      csr_write(REG_SPARE, junk);
      csr_write(REG_BOOST_TIME, s.boost_time);
      csr_write(REG_RAMP_END, s.ramp_end);
      // upper bits of a speed word are dropped by the block
      csr_write(REG_START_SPEED, {junk[DUR_W-1:SPD_W], s.start_speed});
      csr_write(REG_END_SPEED, {~junk[DUR_W-1:SPD_W], s.end_speed});
      csr_write(REG_OUTTAKE_SPEED, {junk[DUR_W-1:SPD_W], s.outtake_speed});
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [DUR_W-1:0] pick_duration();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 16) return '1;
      if (r < 30) return DUR_W'($urandom);
      return DUR_W'($urandom_range(1, 2500));
   endfunction

   function automatic logic [SPD_W-1:0] pick_speed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return SPD_W'($urandom_range(0, 1023));
   endfunction

   function automatic cfg_type pick_setting(input int idx);
      cfg_type s;
      case (idx)
         0: s = '{RST_OUTTAKE_TIME, RST_SCORE_TIME, RST_BOOST_TIME, RST_RAMP_END,
                  RST_START_SPEED, RST_END_SPEED, RST_OUTTAKE_SPEED};
         1: s = '{'1, '1, '1, '1, '1, '1, '1};
         2: s = '{'0, '0, '0, '0, '0, '0, '0};
         default: s = '{pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                        pick_speed(), pick_speed(), pick_speed()};
      endcase
      return s;
   endfunction

   initial begin
      cfg_type           setting;
      logic [TIME_W-1:0] stamp;
      logic              btn;
      int                hold, step_hi, r;

      req_bus.valid        = 1'b0;
      req_bus.button_level = 1'b0;
      req_bus.now_ms       = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.addr         = REG_OUTTAKE_TIME;
      csr_bus.wdata        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default timings; the run starts just short of the timestamp wrap
      send_poll(1'b0, 32'h0000_0000);
      send_poll(1'b1, 32'hFFFF_FF38);
      send_poll(1'b1, 32'hFFFF_FF9C);
      send_poll(1'b0, 32'hFFFF_FFCE);
      send_poll(1'b1, 32'hFFFF_FFFF);   // edge while busy
      send_poll(1'b1, 32'h0000_0000);   // outtake over across the wrap
      send_poll(1'b0, 32'd0);
      send_poll(1'b0, 32'd499);
      send_poll(1'b0, 32'd500);
      send_poll(1'b0, 32'd1000);
      send_poll(1'b0, 32'd1333);        // falling ramp, fraction rounds down
      send_poll(1'b0, 32'd1499);
      send_poll(1'b0, 32'd1500);
      send_poll(1'b1, 32'd2499);
      send_poll(1'b1, 32'd2500);        // end of scoring
      send_poll(1'b1, 32'd3000);        // held button, no new run

      // zero durations end each phase on its first poll
      apply_setting('{outtake_time: 16'd0, score_time: 16'd0, boost_time: 16'd500,
                      ramp_end: 16'd1500, start_speed: 10'd500, end_speed: 10'd200,
                      outtake_speed: 10'd1023});
      send_poll(1'b0, 32'd5);
      send_poll(1'b1, 32'd7);
      send_poll(1'b0, 32'd7);

      // empty ramp window goes straight from boost to tail
      apply_setting('{outtake_time: 16'd3, score_time: 16'hFFFF, boost_time: 16'd10,
                      ramp_end: 16'd5, start_speed: 10'd0, end_speed: 10'd1023,
                      outtake_speed: 10'd1023});
      send_poll(1'b1, 32'd100);
      send_poll(1'b0, 32'd103);
      send_poll(1'b0, 32'd110);
      send_poll(1'b0, 32'd113);

      // rising ramp over the widest window, written mid-run
      apply_setting('{outtake_time: 16'd3, score_time: 16'hFFFF, boost_time: 16'd0,
                      ramp_end: 16'hFFFF, start_speed: 10'd0, end_speed: 10'd1023,
                      outtake_speed: 10'd1023});
      send_poll(1'b0, 32'd40103);
      send_poll(1'b0, 32'd65638);

      stamp = $urandom;
      hold  = 0;
      for (int ph = 0; ph < N_SETTINGS; ph++) begin
         setting = pick_setting(ph);
         apply_setting(setting);
         steady  <= (ph == STEADY_SETTING);
         // step size keeps a whole run to a few dozen polls
         step_hi = (int'(setting.outtake_time) + int'(setting.score_time)) / 20 + 1;
         repeat (POLLS_PER_SETTING) begin
            r = $urandom_range(0, 99);
            if (hold > 0) begin
               btn = 1'b1;
               hold--;
            end else if (r < 12) begin
               btn  = 1'b1;
               hold = $urandom_range(0, 3);
            end else begin
               btn = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (r < 4)
               stamp = $urandom;
            else if (r < 6)
               stamp = stamp - $urandom_range(1, 50);
            else
               stamp = stamp + $urandom_range(0, step_hi);
            send_poll(btn, stamp);
         end
      end

      steady <= 1'b0;
      drain_commands();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("timed_intake_macro_sequencer_tb: PASS");
      end else begin
         $display("timed_intake_macro_sequencer_tb: FAIL");
      end
      $finish;
   end

endmodule
